// ===== sv/dwim_pkg.sv =====
// shared constants, types and request codes for the digit window id matcher
// no dependencies; every other file imports this package
package dwim_pkg;

    // configuration of the window and the id table
    localparam int WINDOW_DIGITS = 9;
    localparam int TABLE_DEPTH   = 1024;

    // field widths
    localparam int REQ_W  = 2;
    localparam int DIG_W  = 4;
    localparam int VAL_W  = 30;
    localparam int POS_W  = 40;
    localparam int HITS_W = 32;

    // derived widths
    localparam int WIN_W  = DIG_W * WINDOW_DIGITS;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SEEN_W = $clog2(WINDOW_DIGITS + 1);

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [DIG_W-1:0]  t_digit;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [HITS_W-1:0] t_hits;
    typedef logic [WIN_W-1:0]  t_win;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SEEN_W-1:0] t_seen;

    // request codes
    localparam t_req REQ_LOAD  = 2'd0;
    localparam t_req REQ_CLEAR = 2'd1;
    localparam t_req REQ_DIGIT = 2'd2;

    // largest legal decimal digit
    localparam t_digit DIGIT_MAX = 4'd9;

    // result of the digit to binary converter
    typedef struct packed {
        logic   done;
        t_value value;
    } t_conv_res;

endpackage

// ===== sv/dwim_table.sv =====
// id table memory: one write port, one read port with registered read data
// depends on dwim_pkg
module dwim_table (
    input  logic            i_clk,
    input  logic            i_we,
    input  dwim_pkg::t_addr i_waddr,
    input  dwim_pkg::t_value i_wdata,
    input  logic            i_re,
    input  dwim_pkg::t_addr i_raddr,
    output dwim_pkg::t_value o_rdata
);
    import dwim_pkg::*;

    t_value r_mem [TABLE_DEPTH];
    t_value r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dwim_conv.sv =====
// iterative bcd window to binary converter, one digit per cycle
// depends on dwim_pkg
module dwim_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dwim_pkg::t_win      i_window,
    output dwim_pkg::t_conv_res o_res
);
    import dwim_pkg::*;

    t_win   r_sh;
    t_value r_acc;
    t_seen  r_left;
    logic   r_busy;
    logic   r_done;

    t_digit nib;
    t_value n_acc;

    // oldest digit sits in the top nibble; acc = acc * 10 + digit
    assign nib   = r_sh[WIN_W-1 -: DIG_W];
    assign n_acc = (r_acc << 3) + (r_acc << 1) + VAL_W'(nib);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= SEEN_W'(WINDOW_DIGITS);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == SEEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_window;
            r_acc <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << DIG_W;
            r_acc <= n_acc;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_acc;

endmodule

// ===== sv/digit_window_id_matcher.sv =====
// digit item that fills the window: conversion of the window, then one table read per loaded
// entry, stopping early on a hit; input stalls from acceptance until the result is registered
// load, clear and ignored items, and digits that do not fill the window, stay in idle
// the result waits in an output register; the next result holds while it is stalled
// reset (synchronous, active low) empties the table and clears window, position
// and hit count; table contents are not cleared
module digit_window_id_matcher (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dwim_pkg::t_req    i_req_type,
    input  dwim_pkg::t_value  i_entry_value,
    input  dwim_pkg::t_digit  i_digit,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output dwim_pkg::t_hits   o_hit_number,
    output dwim_pkg::t_pos    o_window_start,
    output dwim_pkg::t_value  o_window_value
);
    import dwim_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    t_cnt       r_id_count;
    t_win       r_win;
    t_seen      r_seen;
    t_pos       r_pos;
    t_hits      r_hit_cnt;
    t_pos       r_start;
    t_value     r_value;
    t_cnt       r_idx;
    logic       r_pend;
    logic       r_hit;
    logic       r_out_valid;
    logic       r_o_hit;
    t_hits      r_o_hit_number;
    t_pos       r_o_start;
    t_value     r_o_value;

    logic       accept;
    logic       is_load;
    logic       is_digit;
    logic       table_we;
    t_win       n_win;
    t_seen      n_seen;
    logic       conv_start;
    t_conv_res  conv_res;
    logic       rd_en;
    t_value     rd_data;
    logic       match;
    logic       out_free;

    // item decode
    assign accept   = i_in_valid && !o_in_stall;
    assign is_load  = accept && (i_req_type == REQ_LOAD);
    assign is_digit = accept && (i_req_type == REQ_DIGIT) && (i_digit <= DIGIT_MAX);
    assign table_we = is_load && (r_id_count < CNT_W'(TABLE_DEPTH));

    // window shift and fill count
    assign n_win  = WIN_W'({r_win, i_digit});
    assign n_seen = (r_seen < SEEN_W'(WINDOW_DIGITS)) ? r_seen + 1'b1 : r_seen;
    assign conv_start = is_digit && (n_seen == SEEN_W'(WINDOW_DIGITS));

    assign o_in_stall = (r_state != S_IDLE);

    // scan: one read per cycle, compare in the following cycle
    assign rd_en    = (r_state == S_SCAN) && (r_idx < r_id_count);
    assign match    = r_pend && (rd_data == r_value);
    assign out_free = !r_out_valid || !i_out_stall;

    dwim_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (conv_start),
        .i_window (n_win),
        .o_res    (conv_res)
    );

    dwim_table u_table (
        .i_clk   (i_clk),
        .i_we    (table_we),
        .i_waddr (r_id_count[ADDR_W-1:0]),
        .i_wdata (i_entry_value),
        .i_re    (rd_en),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_id_count  <= '0;
            r_win       <= '0;
            r_seen      <= '0;
            r_pos       <= '0;
            r_hit_cnt   <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load a finished result, drop a taken one
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (table_we) begin
                        r_id_count <= r_id_count + 1'b1;
                    end
                    if (accept && (i_req_type == REQ_CLEAR)) begin
                        r_id_count <= '0;
                    end
                    if (is_digit) begin
                        r_win  <= n_win;
                        r_seen <= n_seen;
                        r_pos  <= r_pos + POS_W'(1);
                    end
                    if (conv_start) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (conv_res.done) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx  <= r_idx + CNT_W'(rd_en);
                    r_pend <= rd_en;
                    if (match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (!rd_en && !r_pend) begin
                        r_hit   <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        if (r_hit) begin
                            r_hit_cnt <= r_hit_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-item payload
    always_ff @(posedge i_clk) begin
        if (conv_start) begin
            r_start <= r_pos + POS_W'(1) - POS_W'(WINDOW_DIGITS);
        end
        if ((r_state == S_CONV) && conv_res.done) begin
            r_value <= conv_res.value;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_o_hit        <= r_hit;
            r_o_hit_number <= r_hit_cnt;
            r_o_start      <= r_start;
            r_o_value      <= r_value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_o_hit;
    assign o_hit_number   = r_o_hit_number;
    assign o_window_start = r_o_start;
    assign o_window_value = r_o_value;

    // table fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_count <= CNT_W'(TABLE_DEPTH))
        else $error("id count beyond table depth");

    // scan index never passes the count of loaded entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_id_count))
        else $error("scan index past loaded entries");

    // a result only appears once the window is full
    a_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_seen == SEEN_W'(WINDOW_DIGITS)))
        else $error("result with partial window");

    // a delivered hit advances the hit count by one
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free && r_hit) |=>
            (r_hit_cnt == $past(r_hit_cnt) + 1'b1))
        else $error("hit count did not advance");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for digit_window_id_matcher: a queue-fed driver, a monitor and
// a predictor of the id table, digit window, stream position and hit count
// depends on dwim_pkg and digit_window_id_matcher
`timescale 1ns / 1ps

module tb_top;
    import dwim_pkg::*;

    // request code that the block ignores
    localparam t_req REQ_NONE = 2'd3;

    localparam int HALF_PERIOD  = 2;
    localparam int CYCLE_LIMIT  = 10000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = WINDOW_DIGITS + TABLE_DEPTH + 3 + 64;
    localparam int GEN_IDS_MAX  = 24;
    localparam int DEC_MAX      = 999999999;

    typedef struct packed {
        t_req   req;
        t_value entry;
        t_digit dig;
    } t_req_item;

    typedef struct {
        logic   hit;
        t_hits  hit_number;
        t_pos   start;
        t_value value;
    } t_window_match;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_stall;
    t_req   drv_req   = REQ_LOAD;
    t_value drv_entry = '0;
    t_digit drv_digit = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   res_hit;
    t_hits  res_hit_number;
    t_pos   res_window_start;
    t_value res_window_value;

    t_req_item     pending_q[$];
    t_window_match window_results_q[$];
    t_value        gen_ids[$];

    int pushed_cnt    = 0;
    int accepted_cnt  = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_cnt      = 0;
    bit hold_req      = 1'b0;
    bit in_taken      = 1'b0;

    // predicted block state
    t_value      id_tbl [TABLE_DEPTH];
    int unsigned id_cnt      = 0;
    t_win        win_nib     = '0;
    int unsigned seen        = 0;
    t_pos        next_pos    = '0;
    t_hits       hits_so_far = '0;

    digit_window_id_matcher dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (drv_req),
        .i_entry_value  (drv_entry),
        .i_digit        (drv_digit),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_hit          (res_hit),
        .o_hit_number   (res_hit_number),
        .o_window_start (res_window_start),
        .o_window_value (res_window_value)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // apply one item to the predicted state, returns 1 when it yields a window result
    function automatic bit step_matcher(input t_req_item it, output t_window_match res);
        int unsigned acc;
        int          k;
        bit          found;
        t_value      win_val;
        res.hit        = 1'b0;
        res.hit_number = '0;
        res.start      = '0;
        res.value      = '0;
        found          = 1'b0;
        acc            = 0;
        case (it.req)
            REQ_LOAD: begin
                if (id_cnt < TABLE_DEPTH) begin
                    id_tbl[id_cnt] = it.entry;
                    id_cnt++;
                end
                return 1'b0;
            end
            REQ_CLEAR: begin
                id_cnt = 0;
                return 1'b0;
            end
            REQ_DIGIT: ;
            default: return 1'b0;
        endcase
        if (it.dig > DIGIT_MAX) return 1'b0;
        // shift the digit in, newest in the low nibble
        win_nib = (win_nib << DIG_W) | t_win'(it.dig);
        if (seen < WINDOW_DIGITS) seen++;
        res.start = next_pos + 1 - WINDOW_DIGITS;
        next_pos  = next_pos + 1;
        if (seen < WINDOW_DIGITS) return 1'b0;
        // oldest digit most significant
        for (k = WINDOW_DIGITS - 1; k >= 0; k--) begin
            acc = acc * 10 + int'(win_nib[k*DIG_W +: DIG_W]);
        end
        win_val = t_value'(acc);
        for (int unsigned i = 0; i < id_cnt; i++) begin
            if (id_tbl[i] == win_val) begin
                found = 1'b1;
                break;
            end
        end
        res.hit        = found;
        res.hit_number = hits_so_far;
        res.value      = win_val;
        if (found) hits_so_far++;
        return 1'b1;
    endfunction

    // item acceptance and prediction
    always @(posedge clk) begin
        t_window_match m;
        in_taken = 1'b0;
        if (rst_n && in_valid && !in_stall) begin
            in_taken = 1'b1;
            accepted_cnt++;
            if (step_matcher('{drv_req, drv_entry, drv_digit}, m))
                window_results_q.push_back(m);
        end
    end

    // driver: next item after acceptance, with random gaps between items
    always @(negedge clk) begin
        t_req_item cur;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                cur = pending_q.pop_front();
                drv_req   <= cur.req;
                drv_entry <= cur.entry;
                drv_digit <= cur.dig;
                in_valid  <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: one long hold when requested, random otherwise
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
            out_stall <= 1'b1;
            hold_cnt++;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // monitor: compare each result with the oldest predicted window
    always @(posedge clk) begin
        t_window_match want;
        if (rst_n && out_valid && !out_stall) begin
            if (window_results_q.size() == 0) begin
                $error("result with no expectation: window_value %0d", res_window_value);
                err_cnt++;
            end else begin
                want = window_results_q.pop_front();
                if (res_hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, res_hit);
                    err_cnt++;
                end
                if (res_hit_number !== want.hit_number) begin
                    $error("hit_number: expected %0d, actual %0d",
                           want.hit_number, res_hit_number);
                    err_cnt++;
                end
                if (res_window_start !== want.start) begin
                    $error("window_start: expected %0d, actual %0d",
                           want.start, res_window_start);
                    err_cnt++;
                end
                if (res_window_value !== want.value) begin
                    $error("window_value: expected %0d, actual %0d",
                           want.value, res_window_value);
                    err_cnt++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_item(input t_req req, input t_value entry, input t_digit dig);
        pending_q.push_back('{req, entry, dig});
        pushed_cnt++;
    endtask

    task automatic load_id(input t_value v);
        push_item(REQ_LOAD, v, t_digit'($urandom_range(0, 15)));
    endtask

    task automatic send_digit(input t_digit d);
        push_item(REQ_DIGIT, t_value'($urandom()), d);
    endtask

    // nine digits of a decimal id, most significant first
    task automatic send_id_digits(input int unsigned v);
        t_digit ds [WINDOW_DIGITS];
        int     k;
        for (k = WINDOW_DIGITS - 1; k >= 0; k--) begin
            ds[k] = t_digit'(v % 10);
            v     = v / 10;
        end
        for (k = 0; k < WINDOW_DIGITS; k++) send_digit(ds[k]);
    endtask

    // hold off new items until everything sent has been answered
    task automatic wait_drained();
        do @(negedge clk);
        while (accepted_cnt != pushed_cnt || window_results_q.size() != 0);
        @(posedge clk);
    endtask

    // ids from the table embedded in random digits, with loads, some clears and noise
    task automatic random_phase(input int target);
        int     done_cnt;
        int     sel;
        int     pick;
        t_value v;
        done_cnt = 0;
        while (done_cnt < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                push_item(REQ_CLEAR, t_value'($urandom()), t_digit'($urandom_range(0, 15)));
                gen_ids.delete();
                done_cnt++;
            end else if (sel < 22) begin
                if (gen_ids.size() < GEN_IDS_MAX) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) v = t_value'($urandom_range(0, DEC_MAX));
                    else if (pick < 85) v = t_value'($urandom());
                    else v = t_value'($urandom_range(0, 999));
                    load_id(v);
                    gen_ids.push_back(v);
                    done_cnt++;
                end
            end else if (sel < 42 && gen_ids.size() != 0) begin
                v = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
                if (v <= DEC_MAX) begin
                    send_id_digits(v);
                    done_cnt += WINDOW_DIGITS;
                end
            end else if (sel < 93) begin
                send_digit(t_digit'($urandom_range(0, 9)));
                done_cnt++;
            end else if (sel < 96) begin
                push_item(REQ_NONE, t_value'($urandom()), t_digit'($urandom_range(0, 15)));
            end else begin
                send_digit(t_digit'($urandom_range(10, 15)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, ignored items, first full window, clear then reload
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_id(t_value'(123456789));
        load_id(t_value'(0));
        load_id(t_value'('1));
        load_id(t_value'(DEC_MAX));
        for (int d = 1; d <= 8; d++) send_digit(t_digit'(d));
        send_digit(t_digit'(15));
        push_item(REQ_NONE, '1, '1);
        send_digit(t_digit'(9));
        push_item(REQ_CLEAR, '0, '0);
        send_digit(t_digit'(0));
        load_id(t_value'(345678900));
        send_digit(t_digit'(0));
        wait_drained();

        // full table: load past the end is dropped, scans reach the last entry
        tx_idle_pct = 28;
        rx_idle_pct = 76;
        push_item(REQ_CLEAR, '0, '0);
        load_id(t_value'(0));
        for (int n = 1; n < TABLE_DEPTH - 1; n++) load_id(t_value'($urandom_range(0, DEC_MAX)));
        load_id(t_value'(DEC_MAX));
        load_id(t_value'(111111111));
        send_id_digits(DEC_MAX);
        send_id_digits(111111111);
        send_id_digits(0);
        push_item(REQ_CLEAR, '0, '0);
        wait_drained();

        // random stream, sender idles less than receiver
        gen_ids.delete();
        random_phase(195);
        wait_drained();

        // random stream, receiver idles less than sender
        tx_idle_pct = 76;
        rx_idle_pct = 28;
        random_phase(195);
        wait_drained();

        // random stream without idling, with one long receiver hold
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(195);
        hold_req = 1'b1;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (window_results_q.size() != 0) begin
            $error("expectations left over: %0d", window_results_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
